/* hw/rtl/kmpm_pkg.sv */
`timescale 1ns / 1ps

package kmpm_pkg;

	localparam int NUM_PATTERNS_DEF  = 15;
	localparam int HISTORY_CHARS_DEF = 10;

	// pattern table geometry
	localparam int ROM_ROWS = 15;
	localparam int ROW_LEN  = 12;
	localparam int CODE_W   = 5;
	localparam int PAT_W    = ROW_LEN * CODE_W;
	localparam int IDX_W    = 4;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 8;

	localparam logic [7:0] CHAR_UPPER_A = 8'd65;
	localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;
	localparam logic [7:0] CHAR_LOWER_A = 8'd97;
	localparam logic [7:0] CHAR_LAST_OK = 8'd128;

	typedef logic [ROW_LEN*8-1:0] pat_row_t;

	// strings are right aligned: last character in the low byte
	localparam pat_row_t PAT_ROM [ROM_ROWS] = '{
		"idchoppers", "iddqd", "idkfa", "idfa", "idclip",
		"idbeholdh", "idbeholdm", "idbeholdv", "idbeholds", "idbeholdi",
		"idbeholdr", "idbeholda", "idbeholdl", "idbehold", "idrate"
	};

	function automatic int pat_len(input int r);
		int n;
		pat_row_t row;
		n = 0;
		row = '0;
		if (r < ROM_ROWS) begin
			row = PAT_ROM[r];
			for (int k = 0; k < ROW_LEN; k++) begin
				if (row[8*k +: 8] != 8'd0) n++;
			end
		end
		return n;
	endfunction

	function automatic logic [PAT_W-1:0] pat_code(input int r);
		logic [PAT_W-1:0] c;
		logic [7:0] ch;
		c = '0;
		if (r < ROM_ROWS) begin
			for (int k = 0; k < ROW_LEN; k++) begin
				ch = PAT_ROM[r][8*k +: 8];
				if (ch != 8'd0) c[CODE_W*k +: CODE_W] = CODE_W'(ch - CHAR_LOWER_A);
			end
		end
		return c;
	endfunction

	function automatic logic [PAT_W-1:0] pat_mask(input int r);
		logic [PAT_W-1:0] m;
		m = '0;
		if (r < ROM_ROWS) begin
			for (int k = 0; k < ROW_LEN; k++) begin
				if (PAT_ROM[r][8*k +: 8] != 8'd0) m[CODE_W*k +: CODE_W] = '1;
			end
		end
		return m;
	endfunction

endpackage

/* hw/rtl/keystroke_multi_pattern_matcher.sv */
`timescale 1ns / 1ps
// an accepted input word is registered in key_s1, and its result in the output register
// throughput: one word per cycle unless m_tready stalls; one history update per word
// the history register and the pattern compare sit between the input and output registers
// reset (arst_n low, asynchronous): history cleared, both stages emptied
// a byte outside 'a'..0x80 after lower-casing clears the history and reports no match

module keystroke_multi_pattern_matcher #(
	parameter int NUM_PATTERNS  = kmpm_pkg::NUM_PATTERNS_DEF,
	parameter int HISTORY_CHARS = kmpm_pkg::HISTORY_CHARS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [kmpm_pkg::IN_W-1:0]  s_tdata,   // [7:0] key_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [kmpm_pkg::OUT_W-1:0] m_tdata    // [0] matched, [4:1] pattern_index, [7:5] zero
);
	import kmpm_pkg::*;

	localparam int HW = HISTORY_CHARS * CODE_W;

	logic             valid_s1;
	logic [IN_W-1:0]  key_s1;
	logic [HW-1:0]    hist_q;
	logic             out_valid_q;
	logic             matched_q;
	logic [IDX_W-1:0] idx_q;

	logic              adv;
	logic [7:0]        key_lc;
	logic              code_ok;
	logic [CODE_W-1:0] code;
	logic [HW-1:0]     hist_new;
	logic [PAT_W-1:0]  hist_ext;
	logic [NUM_PATTERNS-1:0] match;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// lower-case A-Z only, then take the offset from 'a'
	assign key_lc  = (key_s1 >= CHAR_UPPER_A && key_s1 <= CHAR_UPPER_Z) ?
		key_s1 + CASE_OFFSET : key_s1;
	assign code_ok = (key_lc >= CHAR_LOWER_A) && (key_lc <= CHAR_LAST_OK);
	assign code    = CODE_W'(key_lc - CHAR_LOWER_A);

	assign hist_new = code_ok ? HW'({hist_q, code}) : '0;
	assign hist_ext = PAT_W'(hist_new);

	for (genvar r = 0; r < NUM_PATTERNS; r++) begin : g_pat
		localparam int               LEN  = pat_len(r);
		localparam logic [PAT_W-1:0] CODE = pat_code(r);
		localparam logic [PAT_W-1:0] MASK = pat_mask(r);
		if (LEN == 0 || LEN > HISTORY_CHARS) begin : g_never
			assign match[r] = 1'b0;
		end else begin : g_cmp
			assign match[r] = code_ok && ((hist_ext & MASK) == CODE);
		end
	end

	// lowest index wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int r = NUM_PATTERNS - 1; r >= 0; r--) begin
			if (match[r]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv) hist_q <= hist_new;
			if (adv) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) key_s1 <= s_tdata;
		if (adv) begin
			matched_q <= hit;
			idx_q     <= hit_idx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({idx_q, matched_q});

	a_clear_on_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !code_ok) |=> (hist_q == '0))
		else $error("history not cleared after a non-letter word");

	a_shift_in: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && code_ok) |=> (hist_q[CODE_W-1:0] == $past(code)))
		else $error("newest code missing from history");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !matched_q) |-> (idx_q == '0))
		else $error("nonzero index without a match");

	a_no_match_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !code_ok) |=> !matched_q)
		else $error("match reported for a non-letter word");

endmodule

/* bench/tb_keystroke_multi_pattern_matcher.sv */
`timescale 1ns / 1ps

module tb_keystroke_multi_pattern_matcher;

	localparam int NUM_PAT    = 15;
	localparam int HIST_CHARS = 10;
	localparam int HIST_W     = HIST_CHARS * 5;
	localparam int RAND_WORDS = 700;
	localparam int MAX_CYCLES = 200000;
	localparam int HOLD_LEN   = 80;
	localparam int DRAIN_WAIT = 10;
	localparam int MAX_REPORT = 10;

	localparam logic [7:0] KEY_UPPER_A = 8'd65;
	localparam logic [7:0] KEY_UPPER_Z = 8'd90;
	localparam logic [7:0] KEY_LOWER_A = 8'd97;
	localparam logic [7:0] KEY_LOWER_Z = 8'd122;
	localparam logic [7:0] KEY_TOP_OK  = 8'd128;

	typedef struct packed {
		logic       matched;
		logic [3:0] index;
	} hit_t;

	string pat_text [NUM_PAT] = '{
		"idchoppers", "iddqd", "idkfa", "idfa", "idclip",
		"idbeholdh", "idbeholdm", "idbeholdv", "idbeholds", "idbeholdi",
		"idbeholdr", "idbeholda", "idbeholdl", "idbehold", "idrate"
	};

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [kmpm_pkg::IN_W-1:0]    s_tdata  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [kmpm_pkg::OUT_W-1:0]   m_tdata;

	logic [7:0]      key_queue [$];
	hit_t            expected_hits [$];
	logic [HIST_W-1:0] history = '0;

	int sent_cnt    = 0;
	int rx_cnt      = 0;
	int err_cnt     = 0;
	int cycle_cnt   = 0;
	int tx_idle_pct = 11;
	int rx_idle_pct = 63;
	int hold_left   = 0;
	logic hold_go   = 1'b0;
	logic hold_done = 1'b0;

	keystroke_multi_pattern_matcher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// shift one key into the history and find the lowest pattern it now ends with
	function automatic hit_t predict_hit(input logic [7:0] key);
		hit_t        h;
		int          lc;
		int          code;
		int          n;
		string       s;
		logic [63:0] pc;
		logic [63:0] pm;
		h = '0;
		lc = key;
		if (key >= KEY_UPPER_A && key <= KEY_UPPER_Z) lc = lc + 32;
		code = lc - 97;
		if (code < 0 || code > 31) begin
			history = '0;
			return h;
		end
		history = {history[HIST_W-6:0], 5'(code)};
		for (int r = 0; r < NUM_PAT; r++) begin
			s = pat_text[r];
			n = s.len();
			if (n == 0 || n > HIST_CHARS) continue;
			pc = '0;
			pm = '0;
			for (int k = 0; k < n; k++) begin
				pc = (pc << 5) | 64'((int'(s.getc(k)) - 97) & 31);
				pm = (pm << 5) | 64'd31;
			end
			if (!h.matched && (history & pm[HIST_W-1:0]) == pc[HIST_W-1:0]) begin
				h.matched = 1'b1;
				h.index   = 4'(r);
			end
		end
		return h;
	endfunction

	function automatic logic [7:0] random_case(input logic [7:0] ch);
		if (ch >= KEY_LOWER_A && ch <= KEY_LOWER_Z && $urandom_range(0, 2) == 0)
			return ch - 8'd32;
		return ch;
	endfunction

	task automatic push_text(input string s, input bit mixed);
		logic [7:0] ch;
		for (int k = 0; k < s.len(); k++) begin
			ch = s.getc(k);
			key_queue.push_back(mixed ? random_case(ch) : ch);
		end
	endtask

	// typed cheat words with random case, stray letters, typos and separators
	task automatic fill_random();
		int          kind;
		int          r;
		int          pre;
		int          typo;
		string       s;
		logic [7:0]  ch;
		while (key_queue.size() < RAND_WORDS + 24) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				pre = $urandom_range(0, 3);
				for (int k = 0; k < pre; k++)
					key_queue.push_back(random_case(8'($urandom_range(97, 122))));
				r = $urandom_range(0, NUM_PAT - 1);
				s = pat_text[r];
				typo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, s.len() - 1) : -1;
				for (int k = 0; k < s.len(); k++) begin
					ch = (k == typo) ? 8'($urandom_range(97, 122)) : 8'(s.getc(k));
					key_queue.push_back(random_case(ch));
				end
			end else if (kind < 85) begin
				key_queue.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 95) begin
				key_queue.push_back(8'($urandom_range(int'(KEY_LOWER_A), int'(KEY_TOP_OK))));
			end else begin
				key_queue.push_back(8'h20);
			end
		end
	endtask

	// sender: predict on every accepted word, then offer the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_hits.push_back(predict_hit(s_tdata));
				sent_cnt <= sent_cnt + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (key_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= key_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the pipeline backs up into the input
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	// receiver: compare each result word with the oldest prediction
	always @(posedge clk) begin
		hit_t exp_hit;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				rx_cnt <= rx_cnt + 1;
				if (expected_hits.size() == 0) begin
					err_cnt = err_cnt + 1;
					if (err_cnt <= MAX_REPORT)
						$display("unexpected result word: matched=%0d index=%0d",
							m_tdata[0], m_tdata[4:1]);
				end else begin
					exp_hit = expected_hits.pop_front();
					if (m_tdata[0] !== exp_hit.matched || m_tdata[4:1] !== exp_hit.index) begin
						err_cnt = err_cnt + 1;
						if (err_cnt <= MAX_REPORT)
							$display("result %0d: expected matched=%0d index=%0d, got matched=%0d index=%0d",
								rx_cnt, exp_hit.matched, exp_hit.index,
								m_tdata[0], m_tdata[4:1]);
					end
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= MAX_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int total;
		// edge bytes: null, top byte, just below 'a', first byte past the code range,
		// last byte in range, both ends of the upper-case letters, 'z'
		key_queue.push_back(8'h00);
		key_queue.push_back(8'hFF);
		key_queue.push_back(8'h60);
		key_queue.push_back(8'h81);
		key_queue.push_back(KEY_TOP_OK);
		key_queue.push_back(KEY_UPPER_A);
		key_queue.push_back(KEY_UPPER_Z);
		key_queue.push_back(KEY_LOWER_Z);
		push_text("iddqd", 1'b0);
		push_text("IDKFA", 1'b0);
		push_text("idrate", 1'b0);
		fill_random();
		total = key_queue.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (sent_cnt >= total / 3);
		tx_idle_pct = 63;
		rx_idle_pct = 11;
		wait (sent_cnt >= 2 * total / 3);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		@(posedge clk);
		hold_go <= 1'b1;

		wait (sent_cnt == total);
		wait (rx_cnt >= sent_cnt);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_cnt == 0 && expected_hits.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
